// ===== design/izd_pkg.sv =====
// Package for the interleaved zero-run dropout counter.
// Holds the item field widths, action codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package izd_pkg;

  localparam int ACTION_W   = 2;
  localparam int SAMPLE_W   = 24;
  localparam int CHAN_W     = 6;
  localparam int LOST_W     = 24;
  localparam int RUN_W      = 8;
  localparam int TOTAL_W    = 31;
  localparam int NCH_W      = 7;
  localparam int FLEN_W     = 8;
  localparam int FPF_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_FILE = 2'd2;

  localparam logic [NCH_W-1:0]  CHANNEL_COUNT_RST   = 7'd5;
  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST    = 8'd74;
  localparam logic [FPF_W-1:0]  FRAMES_PER_FILE_RST = 16'd406;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE   = 2'd0,
    ACT_NEW_FILE = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_READ     = 2'd3
  } action_t;

  typedef struct packed {
    logic [NCH_W-1:0]   n_ch;
    logic [FLEN_W-1:0]  frame_length;
    logic [TOTAL_W-1:0] total;
    logic               settling;
  } cfg_view_t;

endpackage

// ===== design/izd_if.sv =====
// Item channel interfaces for the dropout counter: sample in, result out.
// Depends on izd_pkg.
`timescale 1ns / 1ps

interface izd_in_if;
  logic                                valid;
  logic                                ready;
  izd_pkg::action_t                    action;
  logic signed [izd_pkg::SAMPLE_W-1:0] sample;
  logic [izd_pkg::CHAN_W-1:0]          channel;

  modport source (output valid, action, sample, channel, input ready);
  modport sink   (input valid, action, sample, channel, output ready);
endinterface

interface izd_out_if;
  logic                        valid;
  logic                        ready;
  logic [izd_pkg::CHAN_W-1:0]  channel_out;
  logic [izd_pkg::LOST_W-1:0]  lost_count;
  logic                        frame_lost;
  logic                        ignored;

  modport source (output valid, channel_out, lost_count, frame_lost, ignored, input ready);
  modport sink   (input valid, channel_out, lost_count, frame_lost, ignored, output ready);
endinterface

// ===== design/interleaved_zero_run_dropout_counter.sv =====
// Top level of the interleaved zero-run dropout counter.
// Depends on izd_pkg, izd_in_if, izd_out_if and izd_cfg.
//
// Usage:
//   in_item carries one action per item: a sample, a new-file mark, a clear-all
//   or a read of one channel's lost-frame count. out_item returns exactly one
//   result item for each input item, in order.
//   cfg_we/cfg_idx/cfg_data write channel_count, frame_length and
//   frames_per_file; write only while the block holds no item.
//   Accepted items are registered in the read stage, their results in the
//   output register. Throughput: one item per cycle while out_item is not
//   stalled. Run lengths and counts live in two single-port-read memories; an
//   item reads its entry at acceptance and writes it back as its result is
//   registered, with a bypass for the next item. After reset or a write on
//   cfg_we, in_ready stays low while the per-file sample total is rebuilt.
//   Reset clears all counts, runs, the channel position and the file index.
//   When out_item is stalled, the result waits in the output register, one
//   more item may wait in the read stage, and in_ready then drops.
`timescale 1ns / 1ps

module interleaved_zero_run_dropout_counter #(
  parameter int MAX_CHANNELS = 64,
  parameter int COUNT_BITS   = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  izd_in_if.sink                         in_item,
  izd_out_if.source                      out_item,
  input  logic                           cfg_we,
  input  logic [izd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [izd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import izd_pkg::*;

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  cfg_view_t cfg;

  izd_cfg #(.MAX_CHANNELS(MAX_CHANNELS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .view     (cfg)
  );

  logic [RUN_W-1:0]      zr_mem_r [MAX_CHANNELS];
  logic [COUNT_BITS-1:0] lt_mem_r [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] zr_vld_r, zr_vld_nxt;
  logic [MAX_CHANNELS-1:0] lt_vld_r, lt_vld_nxt;

  logic [AW-1:0]      pos_r;
  logic [TOTAL_W-1:0] fsi_r;

  logic               busy_r;
  action_t            act_r;
  logic               nz_r;
  logic [CHAN_W-1:0]  chan_r;
  logic [AW-1:0]      addr_r;
  logic               oob_r;
  logic               ign_r;
  logic [RUN_W-1:0]      zr_q_r;
  logic [COUNT_BITS-1:0] lt_q_r;
  logic               zr_vq_r;
  logic               lt_vq_r;

  logic               out_valid_r;
  logic [CHAN_W-1:0]  out_chan_r;
  logic [LOST_W-1:0]  out_lost_r;
  logic               out_frame_r;
  logic               out_ign_r;

  logic               complete;
  logic               accept;
  logic [AW-1:0]      pos_eff;
  logic [AW-1:0]      pos_next;
  logic [AW-1:0]      raddr;
  logic               ign_in;
  logic [RUN_W-1:0]      zr_cur;
  logic [COUNT_BITS-1:0] lt_cur;
  logic [RUN_W-1:0]      run;
  logic               hit;
  logic [RUN_W-1:0]      run_w;
  logic [COUNT_BITS-1:0] lt_w;
  logic               zr_we;
  logic               lt_we;

  assign complete      = busy_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !cfg.settling && (!busy_r || complete);
  assign accept        = in_item.valid && in_item.ready;

  always_comb begin
    pos_eff  = (32'(pos_r) < 32'(cfg.n_ch)) ? pos_r : '0;
    pos_next = (32'(pos_eff) + 1 >= 32'(cfg.n_ch)) ? '0 : pos_eff + AW'(1);
    raddr    = (in_item.action == ACT_READ) ? AW'(in_item.channel) : pos_eff;
    ign_in   = (fsi_r >= cfg.total);
  end

  always_comb begin
    zr_cur = zr_vq_r ? zr_q_r : '0;
    lt_cur = lt_vq_r ? lt_q_r : '0;
    if (nz_r) begin
      run = '0;
    end else if (zr_cur < RUN_MAX) begin
      run = zr_cur + RUN_W'(1);
    end else begin
      run = zr_cur;
    end
    hit   = (cfg.frame_length != '0) && (run == cfg.frame_length);
    run_w = hit ? '0 : run;
    lt_w  = (hit && lt_cur != COUNT_MAX) ? lt_cur + COUNT_BITS'(1) : lt_cur;
    zr_we = complete && (act_r == ACT_SAMPLE) && !ign_r;
    lt_we = zr_we && hit;
  end

  always_comb begin
    zr_vld_nxt = zr_vld_r;
    lt_vld_nxt = lt_vld_r;
    if (complete && (act_r == ACT_NEW_FILE || act_r == ACT_CLEAR)) begin
      zr_vld_nxt = '0;
    end else if (zr_we) begin
      zr_vld_nxt[addr_r] = 1'b1;
    end
    if (complete && act_r == ACT_CLEAR) begin
      lt_vld_nxt = '0;
    end else if (lt_we) begin
      lt_vld_nxt[addr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (zr_we) begin
      zr_mem_r[addr_r] <= run_w;
    end
    if (lt_we) begin
      lt_mem_r[addr_r] <= lt_w;
    end
    if (accept) begin
      zr_q_r  <= (zr_we && addr_r == raddr) ? run_w : zr_mem_r[raddr];
      lt_q_r  <= (lt_we && addr_r == raddr) ? lt_w : lt_mem_r[raddr];
      zr_vq_r <= zr_vld_nxt[raddr];
      lt_vq_r <= lt_vld_nxt[raddr];
      act_r   <= in_item.action;
      nz_r    <= (in_item.sample != '0);
      chan_r  <= in_item.channel;
      addr_r  <= raddr;
      oob_r   <= (32'(in_item.channel) >= MAX_CHANNELS);
      ign_r   <= (in_item.action == ACT_SAMPLE) && ign_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zr_vld_r <= '0;
      lt_vld_r <= '0;
      pos_r    <= '0;
      fsi_r    <= '0;
      busy_r   <= 1'b0;
    end else begin
      zr_vld_r <= zr_vld_nxt;
      lt_vld_r <= lt_vld_nxt;
      if (accept) begin
        busy_r <= 1'b1;
        unique case (in_item.action)
          ACT_SAMPLE: begin
            if (!ign_in) begin
              pos_r <= pos_next;
              fsi_r <= fsi_r + TOTAL_W'(1);
            end
          end
          ACT_NEW_FILE, ACT_CLEAR: begin
            pos_r <= '0;
            fsi_r <= '0;
          end
          ACT_READ: ;
          default: ;
        endcase
      end else if (complete) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (complete) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      unique case (act_r)
        ACT_SAMPLE: begin
          out_chan_r  <= CHAN_W'(addr_r);
          out_lost_r  <= ign_r ? LOST_W'(lt_cur) : LOST_W'(lt_w);
          out_frame_r <= !ign_r && hit;
          out_ign_r   <= ign_r;
        end
        ACT_READ: begin
          out_chan_r  <= chan_r;
          out_lost_r  <= oob_r ? '0 : LOST_W'(lt_cur);
          out_frame_r <= 1'b0;
          out_ign_r   <= 1'b0;
        end
        default: begin
          out_chan_r  <= '0;
          out_lost_r  <= '0;
          out_frame_r <= 1'b0;
          out_ign_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.channel_out = out_chan_r;
  assign out_item.lost_count  = out_lost_r;
  assign out_item.frame_lost  = out_frame_r;
  assign out_item.ignored     = out_ign_r;

endmodule

// ===== design/izd_cfg.sv =====
// Configuration registers and the per-file sample total of the dropout counter.
// Total is built over two multiplier stages; settling is high while it catches up.
// Depends on izd_pkg.
`timescale 1ns / 1ps

module izd_cfg #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [izd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [izd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output izd_pkg::cfg_view_t               view
);
  import izd_pkg::*;

  logic [NCH_W-1:0]       cc_r;
  logic [FLEN_W-1:0]      fl_r;
  logic [FPF_W-1:0]       fpf_r;
  logic [NCH_W-1:0]       n_r;
  logic [FLEN_W-1:0]      fl_d_r;
  logic [NCH_W+FLEN_W-1:0] prod_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [1:0]             settle_r;
  logic [NCH_W-1:0]       n_eff;
  logic [NCH_W+FPF_W+FLEN_W-1:0] prod_full;

  always_comb begin
    n_eff = cc_r;
    if (cc_r == '0) begin
      n_eff = NCH_W'(1);
    end else if (32'(cc_r) > MAX_CHANNELS) begin
      n_eff = NCH_W'(MAX_CHANNELS);
    end
  end

  assign prod_full = (NCH_W+FPF_W+FLEN_W)'(prod_r) * (NCH_W+FPF_W+FLEN_W)'(fpf_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r     <= CHANNEL_COUNT_RST;
      fl_r     <= FRAME_LENGTH_RST;
      fpf_r    <= FRAMES_PER_FILE_RST;
      settle_r <= 2'd2;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_CHANNEL_COUNT:   cc_r  <= cfg_data[NCH_W-1:0];
          REG_FRAME_LENGTH:    fl_r  <= cfg_data[FLEN_W-1:0];
          REG_FRAMES_PER_FILE: fpf_r <= cfg_data[FPF_W-1:0];
          default: ;
        endcase
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_eff;
    fl_d_r  <= fl_r;
    prod_r  <= (NCH_W+FLEN_W)'(n_eff) * (NCH_W+FLEN_W)'(fl_r);
    total_r <= prod_full[TOTAL_W-1:0];
  end

  assign view.n_ch         = n_r;
  assign view.frame_length = fl_d_r;
  assign view.total        = total_r;
  assign view.settling     = (settle_r != 2'd0);

endmodule
